FILE: rtl/lcavg_pkg.sv
// ----------------------------------------------------------------------------
// lcavg_pkg
// Shared types, constants and helpers of the multichannel load-cell averager.
// ----------------------------------------------------------------------------
`default_nettype none

package lcavg_pkg;

	// Channel count and index width.
	localparam int POTS  = 4;
	localparam int POT_W = (POTS > 1) ? $clog2(POTS) : 1;

	// Field widths.
	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 32;
	localparam int CNT_W    = 8;
	localparam int WEIGHT_W = 40;
	localparam int CAL_W    = 32;

	// Configuration port.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AVG_SAMPLES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TARE_SAMPLES = CFG_IDX_W'(1);
	localparam int CFG_CAL_BASE = 2;

	// Register reset values.
	localparam logic [CNT_W-1:0]        AVG_SAMPLES_RST  = CNT_W'(10);
	localparam logic [CNT_W-1:0]        TARE_SAMPLES_RST = CNT_W'(20);
	localparam logic signed [CAL_W-1:0] CAL_ONE          = CAL_W'(65536);

	// Iterative divider geometry: 49-bit dividend, 32-bit divisor, one bit per step.
	localparam int DIV_N_W     = 49;
	localparam int DIV_D_W     = 32;
	localparam int DIV_STEPS   = DIV_N_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int FRAC_SHIFT  = 24;

	// Saturation bounds of the weight.
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	// Input function codes.
	localparam logic [1:0] FUNC_MEASURE    = 2'd0;
	localparam logic [1:0] FUNC_TARE       = 2'd1;
	localparam logic [1:0] FUNC_SET_OFFSET = 2'd2;

	// Open window kinds.
	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_MEASURE = 2'd1;
	localparam logic [1:0] MODE_TARE    = 2'd2;

	// One input transaction.
	typedef struct packed {
		logic [1:0]                 func;
		logic [1:0]                 pot;
		logic                       sample_ready;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] offset_value;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]                 channel;
		logic                       ready_res;
		logic signed [SAMPLE_W-1:0] raw_average;
		logic signed [WEIGHT_W-1:0] weight;
		logic signed [SAMPLE_W-1:0] offset;
	} out_item_t;

	// Per-channel state held in the state memory.
	typedef struct packed {
		logic [SUM_W-1:0]           window_sum;
		logic [CNT_W-1:0]           valid_count;
		logic [CNT_W-1:0]           slot_count;
		logic [1:0]                 window_mode;
		logic signed [SAMPLE_W-1:0] tare_offset;
		logic signed [SAMPLE_W-1:0] last_raw;
		logic signed [WEIGHT_W-1:0] last_weight;
		logic                       ready_flag;
	} state_entry_t;

	// Access request to the state memory.
	typedef struct packed {
		logic             rd_en;
		logic [POT_W-1:0] rd_addr;
		logic             wr_en;
		logic [POT_W-1:0] wr_addr;
	} mem_req_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_AVG,
		ST_WGT,
		ST_WRITE,
		ST_EMIT
	} ctrl_state_t;

	// Apply the sign to a quotient magnitude and clamp it to the weight range.
	function automatic logic signed [WEIGHT_W-1:0] sat_weight(
		input logic               neg,
		input logic [DIV_N_W-1:0] mag
	);
		logic [WEIGHT_W-1:0] low;
		logic [DIV_N_W-1:0]  max_mag;
		logic [DIV_N_W-1:0]  min_mag;
		low     = mag[WEIGHT_W-1:0];
		max_mag = {{(DIV_N_W-WEIGHT_W){1'b0}}, WEIGHT_MAX};
		min_mag = {{(DIV_N_W-WEIGHT_W){1'b0}}, WEIGHT_MIN};
		if (!neg) begin
			return (mag > max_mag) ? WEIGHT_MAX : $signed(low);
		end
		return (mag > min_mag) ? WEIGHT_MIN : $signed(-low);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/multichannel_load_cell_averager.sv
// ----------------------------------------------------------------------------
// multichannel_load_cell_averager
// Per-channel windowed averaging of load-cell samples with tare and scaling.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_item) carries one sample slot, one
// tare slot or a direct offset write per transaction. The output channel
// (out_valid, out_stall, out_item) carries one result when a channel's window
// ends, or at once when the first slot of a window is not ready.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata while the block is idle.
// Items are handled one at a time. A slot that does not end a window passes
// through state read, update and write back. A tare window end needs one pass
// and a measure window end two passes of the shared 49-step divider between
// the update and the write back.
// After the write back a result waits until the output register is free, is
// loaded into it, and is driven to out_valid and out_item from that register.
// While out_stall holds a result, the next item is still taken in; only an
// item that produces a further result waits for the output register to free.
// Reset drops any pending result, restores the configuration defaults and
// marks all channel state as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_load_cell_averager import lcavg_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  wire                   out_stall,
	output out_item_t             out_item
);

	// Configuration registers.
	logic [CNT_W-1:0]        avg_samples_q;
	logic [CNT_W-1:0]        tare_samples_q;
	logic signed [CAL_W-1:0] cal_q [POTS];

	// Sequencer and working registers.
	ctrl_state_t  state_q, state_d;
	in_item_t     item_q;
	state_entry_t work_q;
	logic         emit_q;
	logic         emit_rdy_q;
	logic         sum_neg_q;
	logic         avg_zero_q;
	logic         wgt_neg_q;
	out_item_t    out_item_q;
	logic         out_valid_q;

	// Memory and divider hookup.
	mem_req_t            mem_req;
	state_entry_t        rd_entry;
	logic                div_start;
	logic [DIV_N_W-1:0]  div_dividend;
	logic [DIV_D_W-1:0]  div_divisor;
	logic                div_done;
	logic [DIV_N_W-1:0]  div_quotient;

	// Slot update terms.
	logic                is_measure;
	logic [1:0]          mode_new;
	logic                open_win;
	logic                start_fail;
	logic                win_end;
	logic [CNT_W-1:0]    limit_raw;
	logic [CNT_W-1:0]    limit;
	state_entry_t        upd;
	state_entry_t        upd_done;
	state_entry_t        upd_off;
	logic [SUM_W-1:0]    sum_mag;

	// Average and weight terms.
	logic [SUM_W-1:0]           avg_full;
	logic signed [SAMPLE_W-1:0] avg_new;
	logic signed [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]          diff_mag;
	logic signed [CAL_W-1:0]    cal_sel;
	logic [CAL_W-1:0]           cal_mag;
	logic                       out_free;
	logic                       item_ok;

	lcavg_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.wr_data (work_q),
		.rd_data (rd_entry)
	);

	lcavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Configuration writes; a zero calibration is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_samples_q  <= AVG_SAMPLES_RST;
			tare_samples_q <= TARE_SAMPLES_RST;
			for (int i = 0; i < POTS; i++) begin
				cal_q[i] <= CAL_ONE;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_AVG_SAMPLES) begin
				avg_samples_q <= cfg_wdata[CNT_W-1:0];
			end
			if (cfg_index == CFG_TARE_SAMPLES) begin
				tare_samples_q <= cfg_wdata[CNT_W-1:0];
			end
			for (int i = 0; i < POTS; i++) begin
				if (cfg_index == CFG_IDX_W'(CFG_CAL_BASE + i) && cfg_wdata != '0) begin
					cal_q[i] <= $signed(cfg_wdata[CAL_W-1:0]);
				end
			end
		end
	end

	// Slot update on the entry just read from the state memory.
	always_comb begin
		is_measure = (item_q.func == FUNC_MEASURE);
		mode_new   = is_measure ? MODE_MEASURE : MODE_TARE;
		open_win   = (rd_entry.window_mode != mode_new);
		start_fail = open_win && !item_q.sample_ready;
		upd        = rd_entry;
		if (open_win) begin
			upd.window_sum  = '0;
			upd.valid_count = '0;
			upd.slot_count  = '0;
			upd.window_mode = MODE_NONE;
		end
		if (start_fail) begin
			if (is_measure) begin
				upd.ready_flag = 1'b0;
			end
		end else begin
			if (open_win) begin
				if (is_measure) begin
					upd.ready_flag = 1'b1;
				end
				upd.window_mode = mode_new;
			end
			if (item_q.sample_ready) begin
				upd.window_sum  = upd.window_sum
					+ {{(SUM_W-SAMPLE_W){item_q.sample[SAMPLE_W-1]}}, item_q.sample};
				upd.valid_count = upd.valid_count + 1'b1;
			end
			upd.slot_count = upd.slot_count + 1'b1;
		end
		limit_raw = is_measure ? avg_samples_q : tare_samples_q;
		limit     = (limit_raw == '0) ? CNT_W'(1) : limit_raw;
		win_end   = !start_fail && (upd.slot_count >= limit);
		sum_mag   = upd.window_sum[SUM_W-1] ? -upd.window_sum : upd.window_sum;
		// A finished window leaves the channel with no window open.
		upd_done             = upd;
		upd_done.window_sum  = '0;
		upd_done.valid_count = '0;
		upd_done.slot_count  = '0;
		upd_done.window_mode = MODE_NONE;
		// Direct offset write leaves the open window alone.
		upd_off             = rd_entry;
		upd_off.tare_offset = item_q.offset_value;
	end

	// Signed average and the scaling operands.
	always_comb begin
		avg_full = sum_neg_q ? -div_quotient[SUM_W-1:0] : div_quotient[SUM_W-1:0];
		avg_new  = avg_zero_q ? '0 : $signed(avg_full[SAMPLE_W-1:0]);
		diff     = {avg_new[SAMPLE_W-1], avg_new}
			- {work_q.tare_offset[SAMPLE_W-1], work_q.tare_offset};
		diff_mag = diff[SAMPLE_W] ? -diff : diff;
		cal_sel  = cal_q[item_q.pot[POT_W-1:0]];
		cal_mag  = cal_sel[CAL_W-1] ? -cal_sel : cal_sel;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign item_ok  = (int'(in_item.pot) < POTS)
		&& (in_item.func == FUNC_MEASURE || in_item.func == FUNC_TARE
		|| in_item.func == FUNC_SET_OFFSET);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory requests and divider starts.
	always_comb begin
		state_d      = state_q;
		in_stall     = (state_q != ST_IDLE);
		mem_req      = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				mem_req.rd_addr = in_item.pot[POT_W-1:0];
				if (in_valid && item_ok) begin
					mem_req.rd_en = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				if (item_q.func != FUNC_SET_OFFSET && win_end) begin
					div_start    = 1'b1;
					div_dividend = {{(DIV_N_W-SUM_W){1'b0}}, sum_mag};
					div_divisor  = {{(DIV_D_W-CNT_W){1'b0}}, upd.valid_count};
					state_d      = ST_AVG;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_AVG: begin
				if (div_done) begin
					if (item_q.func == FUNC_MEASURE) begin
						div_start    = 1'b1;
						div_dividend = {diff_mag, {FRAC_SHIFT{1'b0}}};
						div_divisor  = cal_mag;
						state_d      = ST_WGT;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_WGT: begin
				if (div_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = item_q.pot[POT_W-1:0];
				state_d         = emit_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					item_q <= in_item;
				end
			end
			ST_READ: begin
				if (item_q.func == FUNC_SET_OFFSET) begin
					work_q <= upd_off;
				end else begin
					work_q     <= win_end ? upd_done : upd;
					emit_rdy_q <= win_end;
					sum_neg_q  <= upd.window_sum[SUM_W-1];
					avg_zero_q <= (upd.valid_count == '0);
				end
			end
			ST_AVG: begin
				if (div_done) begin
					work_q.last_raw <= avg_new;
					if (item_q.func == FUNC_TARE) begin
						work_q.tare_offset <= avg_new;
						work_q.last_weight <= '0;
					end
					wgt_neg_q <= diff[SAMPLE_W] ^ cal_sel[CAL_W-1];
				end
			end
			ST_WGT: begin
				if (div_done) begin
					work_q.last_weight <= sat_weight(wgt_neg_q, div_quotient);
				end
			end
			default: begin
			end
		endcase
	end

	// Result flag of the item in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			emit_q <= (item_q.func != FUNC_SET_OFFSET) && (start_fail || win_end);
		end
	end

	// Output register: loaded from the written-back entry, held while stalled.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_item_q.channel     <= item_q.pot;
			out_item_q.ready_res   <= emit_rdy_q;
			out_item_q.raw_average <= work_q.last_raw;
			out_item_q.weight      <= work_q.last_weight;
			out_item_q.offset      <= work_q.tare_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

FILE: rtl/lcavg_state_mem.sv
// ----------------------------------------------------------------------------
// lcavg_state_mem
// Per-channel state memory: one write and one read port, registered read data.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcavg_state_mem import lcavg_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  mem_req_t     req,
	input  state_entry_t wr_data,
	output state_entry_t rd_data
);

	state_entry_t     mem_q [POTS];
	state_entry_t     rd_data_q;
	logic [POTS-1:0]  vld_q;
	logic             rd_vld_q;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// Entry valid bits, cleared at reset so that unwritten entries read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/lcavg_div.sv
// ----------------------------------------------------------------------------
// lcavg_div
// Unsigned restoring divider, one quotient bit per cycle. Shared by the
// window average and the weight scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module lcavg_div import lcavg_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire [DIV_N_W-1:0]  dividend,
	input  wire [DIV_D_W-1:0]  divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient
);

	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_D_W:0]     trial;
	logic [DIV_D_W:0]     trial_sub;
	logic                 fits;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial     = {rem_q, quo_q[DIV_N_W-1]};
		trial_sub = trial - {1'b0, div_q};
		fits      = (trial >= {1'b0, div_q});
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/lcavg_checker.sv
// ----------------------------------------------------------------------------
// lcavg_checker
// Port-level checks of the averager, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lcavg_checker import lcavg_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input in_item_t  in_item,
	input wire       out_valid,
	input wire       out_stall,
	input out_item_t out_item
);

	// A stalled result transaction stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or was dropped");

	// Items are handled one at a time: a taken slot or offset write stalls the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_item.func == FUNC_MEASURE
		|| in_item.func == FUNC_TARE || in_item.func == FUNC_SET_OFFSET)
		|=> in_stall)
		else $error("input taken again while an item is in flight");

	// A new result only appears while an item is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in flight");

	// A taken result is not shown again on the next cycle unless an item was in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result repeated after transaction");

endmodule

bind multichannel_load_cell_averager lcavg_checker u_lcavg_checker (.*);

`default_nettype wire
